// ===== rtl/core/pdtq_pkg.sv =====
`default_nettype none

package pdtq_pkg;

	localparam int KIND_BITS    = 2;
	localparam int EVICT_BITS   = 2;
	localparam int PORT_PL_BITS = 32;
	localparam int OCC_BITS     = 5;
	localparam int DROP_BITS    = 32;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	localparam logic [KIND_BITS-1:0] KIND_START   = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_UPDATE  = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_END     = 2'd2;
	localparam logic [KIND_BITS-1:0] KIND_REFUSED = 2'd3;

	localparam logic [EVICT_BITS-1:0] EVICT_NONE   = 2'd0;
	localparam logic [EVICT_BITS-1:0] EVICT_UPDATE = 2'd1;
	localparam logic [EVICT_BITS-1:0] EVICT_HEAD   = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/pdtq_store.sv =====
`default_nettype none

module pdtq_store #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 34
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read, so a stalled result can wait on it.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/priority_drop_tx_queue_core.sv =====
`default_nettype none

// Channel   Direction  Handshake             Beat contents
// input     in         in_valid / in_ready   mode, message_kind, message_payload
// output    out        out_valid / out_ready accepted, evicted, pop_valid, pop_kind,
//                                            pop_payload, occupancy, drop_total
//
// A push that fits, a refused push and a pop of an empty queue complete in EXEC; a pop
// also passes through POP to wait on the registered read of the entry memory. A push into
// a full queue makes one read per entry through the single read port, scans for the
// oldest update and moves the later entries forward as their data returns. Reset clears
// pointers, count and drop counter at once; the entry memory is not cleared. A stalled
// result waits in the output register while the next beat is taken; the block then
// holds in its last step until the register frees.

module priority_drop_tx_queue_core #(
	parameter int QUEUE_DEPTH  = 16,
	parameter int PAYLOAD_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        mode,
	input  wire logic [1:0]  message_kind,
	input  wire logic [31:0] message_payload,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             accepted,
	output logic [1:0]       evicted,
	output logic             pop_valid,
	output logic [1:0]       pop_kind,
	output logic [31:0]      pop_payload,
	output logic [4:0]       occupancy,
	output logic [31:0]      drop_total
);

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int SW = IW + 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int PW = PAYLOAD_BITS;
	localparam int KB = pdtq_pkg::KIND_BITS;
	localparam int EW = KB + PW;
	localparam int PP = pdtq_pkg::PORT_PL_BITS;
	localparam int OB = pdtq_pkg::OCC_BITS;
	localparam int DB = pdtq_pkg::DROP_BITS;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_POP,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [DB-1:0] drop_q;

	logic          mode_q;
	logic [KB-1:0] kind_q;
	logic [PW-1:0] payload_q;

	logic [CW-1:0] rd_k_q;
	logic          found_q;
	logic          v_s1;
	logic [IW-1:0] k_s1;

	logic          out_valid_q;
	logic          accepted_q;
	logic [1:0]    evicted_q;
	logic          pop_valid_q;
	logic [KB-1:0] pop_kind_q;
	logic [PW-1:0] pop_pl_q;

	logic          mem_wr_en;
	logic [IW-1:0] mem_wr_addr;
	logic [EW-1:0] mem_wr_data;
	logic          mem_rd_en;
	logic [IW-1:0] mem_rd_addr;
	logic [EW-1:0] mem_rd_data;

	logic          can_emit;
	logic          emit_now;
	logic          full;
	logic          push_ok;
	logic          scan_done;
	logic [IW-1:0] tail_dec;
	logic [IW-1:0] tail_inc;
	logic [IW-1:0] head_inc;
	logic [KB-1:0] rd_kind;
	logic [PW-1:0] rd_pl;
	logic [PW+PP-1:0] pl_in_ext;
	logic [PW+PP-1:0] pl_out_ext;
	logic [CW+OB-1:0] occ_ext;

	function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
	                                           input logic [IW-1:0] off);
		logic [SW-1:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= SW'(QUEUE_DEPTH)) begin
			s = s - SW'(QUEUE_DEPTH);
		end
		return s[IW-1:0];
	endfunction

	assign can_emit  = !out_valid_q || out_ready;
	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign push_ok   = (kind_q != pdtq_pkg::KIND_REFUSED);
	assign scan_done = (rd_k_q == CW'(QUEUE_DEPTH)) && !v_s1;
	assign tail_dec  = (tail_q == '0) ? IW'(QUEUE_DEPTH - 1) : tail_q - IW'(1);
	assign tail_inc  = ring_add(tail_q, IW'(1));
	assign head_inc  = ring_add(head_q, IW'(1));
	assign rd_kind   = mem_rd_data[EW-1:PW];
	assign rd_pl     = mem_rd_data[PW-1:0];

	// A new result is loaded this cycle, so the output register stays valid.
	assign emit_now = can_emit && (((state_q == ST_EXEC)
		&& !(mode_q == pdtq_pkg::MODE_PUSH && push_ok && full)
		&& !(mode_q == pdtq_pkg::MODE_POP && count_q != '0))
		|| (state_q == ST_POP) || (state_q == ST_FINISH));

	assign pl_in_ext  = {{PW{1'b0}}, message_payload};
	assign pl_out_ext = {{PP{1'b0}}, pop_pl_q};
	assign occ_ext    = {{OB{1'b0}}, count_q};

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign accepted    = accepted_q;
	assign evicted     = evicted_q;
	assign pop_valid   = pop_valid_q;
	assign pop_kind    = pop_kind_q;
	assign pop_payload = pl_out_ext[PP-1:0];
	assign occupancy   = occ_ext[OB-1:0];
	assign drop_total  = drop_q;

	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = tail_q;
		mem_wr_data = {kind_q, payload_q};
		mem_rd_en   = 1'b0;
		mem_rd_addr = head_q;
		unique case (state_q)
			ST_EXEC: begin
				if (mode_q == pdtq_pkg::MODE_PUSH) begin
					mem_wr_en = push_ok && !full && can_emit;
				end else begin
					mem_rd_en = (count_q != '0);
				end
			end
			ST_SCAN: begin
				mem_rd_en   = (rd_k_q != CW'(QUEUE_DEPTH));
				mem_rd_addr = ring_add(head_q, rd_k_q[IW-1:0]);
				// Entries after the evicted update move one place toward the head.
				mem_wr_en   = v_s1 && found_q;
				mem_wr_addr = ring_add(head_q, k_s1 - IW'(1));
				mem_wr_data = mem_rd_data;
			end
			ST_FINISH: begin
				mem_wr_en   = can_emit;
				mem_wr_addr = found_q ? tail_dec : tail_q;
			end
			default: begin
			end
		endcase
	end

	pdtq_store #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (EW)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			drop_q      <= '0;
			mode_q      <= pdtq_pkg::MODE_PUSH;
			kind_q      <= pdtq_pkg::KIND_START;
			payload_q   <= '0;
			rd_k_q      <= '0;
			found_q     <= 1'b0;
			v_s1        <= 1'b0;
			k_s1        <= '0;
			out_valid_q <= 1'b0;
			accepted_q  <= 1'b0;
			evicted_q   <= pdtq_pkg::EVICT_NONE;
			pop_valid_q <= 1'b0;
			pop_kind_q  <= pdtq_pkg::KIND_START;
			pop_pl_q    <= '0;
		end else begin
			if (out_valid_q && out_ready && !emit_now) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mode_q    <= mode;
						kind_q    <= message_kind;
						payload_q <= pl_in_ext[PW-1:0];
						state_q   <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (mode_q == pdtq_pkg::MODE_PUSH && push_ok && full) begin
						rd_k_q  <= '0;
						found_q <= 1'b0;
						v_s1    <= 1'b0;
						state_q <= ST_SCAN;
					end else if (mode_q == pdtq_pkg::MODE_POP && count_q != '0) begin
						state_q <= ST_POP;
					end else if (can_emit) begin
						out_valid_q <= 1'b1;
						accepted_q  <= (mode_q == pdtq_pkg::MODE_PUSH) && push_ok;
						evicted_q   <= pdtq_pkg::EVICT_NONE;
						pop_valid_q <= 1'b0;
						pop_kind_q  <= pdtq_pkg::KIND_START;
						pop_pl_q    <= '0;
						if (mode_q == pdtq_pkg::MODE_PUSH && push_ok) begin
							tail_q  <= tail_inc;
							count_q <= count_q + CW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				ST_POP: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						accepted_q  <= 1'b0;
						evicted_q   <= pdtq_pkg::EVICT_NONE;
						pop_valid_q <= 1'b1;
						pop_kind_q  <= rd_kind;
						pop_pl_q    <= rd_pl;
						head_q      <= head_inc;
						count_q     <= count_q - CW'(1);
						state_q     <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					v_s1 <= mem_rd_en;
					k_s1 <= rd_k_q[IW-1:0];
					if (mem_rd_en) begin
						rd_k_q <= rd_k_q + CW'(1);
					end
					if (v_s1 && !found_q && rd_kind == pdtq_pkg::KIND_UPDATE) begin
						found_q <= 1'b1;
					end
					if (scan_done) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						accepted_q  <= 1'b1;
						evicted_q   <= found_q ? pdtq_pkg::EVICT_UPDATE
						                       : pdtq_pkg::EVICT_HEAD;
						pop_valid_q <= 1'b0;
						pop_kind_q  <= pdtq_pkg::KIND_START;
						pop_pl_q    <= '0;
						// With an update gone the tail steps back and forward again;
						// with the head dropped both pointers advance.
						if (!found_q) begin
							head_q <= head_inc;
							tail_q <= tail_inc;
						end
						if (drop_q != '1) begin
							drop_q <= drop_q + DB'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
module testbench;

	localparam int DEPTH            = 16;
	localparam int CYCLE_LIMIT      = 400000;
	localparam int RX_HOLD_CYCLES   = 250;
	localparam int RANDOM_PER_PHASE = 384;
	localparam int MAX_PRINTED      = 40;
	localparam int SETTLE_CYCLES    = 40;

	typedef struct packed {
		logic                           mode;
		logic [pdtq_pkg::KIND_BITS-1:0] kind;
		logic [31:0]                    payload;
		logic                           drain;
		logic                           rx_hold;
		logic [1:0]                     phase;
	} msg_beat_t;

	typedef struct packed {
		logic                            accepted;
		logic [pdtq_pkg::EVICT_BITS-1:0] evicted;
		logic                            pop_valid;
		logic [pdtq_pkg::KIND_BITS-1:0]  pop_kind;
		logic [31:0]                     pop_payload;
		logic [pdtq_pkg::OCC_BITS-1:0]   occupancy;
		logic [pdtq_pkg::DROP_BITS-1:0]  drop_total;
	} step_result_t;

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        in_valid        = 1'b0;
	logic        in_ready;
	logic        mode            = pdtq_pkg::MODE_PUSH;
	logic [1:0]  message_kind    = pdtq_pkg::KIND_START;
	logic [31:0] message_payload = '0;
	logic        out_valid;
	logic        out_ready       = 1'b0;
	logic        accepted;
	logic [1:0]  evicted;
	logic        pop_valid;
	logic [1:0]  pop_kind;
	logic [31:0] pop_payload;
	logic [4:0]  occupancy;
	logic [31:0] drop_total;

	msg_beat_t    pending_msgs[$];
	step_result_t expected_results[$];
	msg_beat_t    next_msg;
	msg_beat_t    driven_msg;
	step_result_t want;

	// Mirror of the queue contents, advanced once per accepted input beat.
	logic [pdtq_pkg::KIND_BITS-1:0] held_kind [DEPTH];
	logic [31:0]                    held_payload [DEPTH];
	int                             head_pos   = 0;
	int                             tail_pos   = 0;
	int                             held_count = 0;
	logic [31:0]                    drop_count = '0;

	int send_idle_pct [3] = '{14, 51, 0};
	int recv_idle_pct [3] = '{51, 14, 0};

	bit beat_taken   = 1'b0;
	int cur_phase    = 0;
	int rx_hold_left = 0;
	int error_count  = 0;
	int result_count = 0;
	int cycle_count  = 0;

	priority_drop_tx_queue_core #(
		.QUEUE_DEPTH (DEPTH),
		.PAYLOAD_BITS(32)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.message_kind   (message_kind),
		.message_payload(message_payload),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.accepted       (accepted),
		.evicted        (evicted),
		.pop_valid      (pop_valid),
		.pop_kind       (pop_kind),
		.pop_payload    (pop_payload),
		.occupancy      (occupancy),
		.drop_total     (drop_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic step_result_t queue_step(msg_beat_t m);
		step_result_t r;
		int victim;
		int i;
		int j;
		r = '0;
		if (m.mode == pdtq_pkg::MODE_PUSH) begin
			if (m.kind != pdtq_pkg::KIND_REFUSED) begin
				if (held_count == DEPTH) begin
					victim = -1;
					for (i = 0; i < held_count; i++) begin
						if (victim < 0
								&& held_kind[(head_pos + i) % DEPTH] == pdtq_pkg::KIND_UPDATE)
							victim = i;
					end
					if (victim >= 0) begin
						// Later entries slide one place toward the head over the gap.
						for (j = victim; j + 1 < held_count; j++) begin
							held_kind[(head_pos + j) % DEPTH] =
								held_kind[(head_pos + j + 1) % DEPTH];
							held_payload[(head_pos + j) % DEPTH] =
								held_payload[(head_pos + j + 1) % DEPTH];
						end
						tail_pos = (tail_pos + DEPTH - 1) % DEPTH;
						r.evicted = pdtq_pkg::EVICT_UPDATE;
					end else begin
						head_pos = (head_pos + 1) % DEPTH;
						r.evicted = pdtq_pkg::EVICT_HEAD;
					end
					held_count--;
					if (drop_count != '1)
						drop_count++;
				end
				held_kind[tail_pos] = m.kind;
				held_payload[tail_pos] = m.payload;
				tail_pos = (tail_pos + 1) % DEPTH;
				held_count++;
				r.accepted = 1'b1;
			end
		end else if (held_count != 0) begin
			r.pop_valid = 1'b1;
			r.pop_kind = held_kind[head_pos];
			r.pop_payload = held_payload[head_pos];
			head_pos = (head_pos + 1) % DEPTH;
			held_count--;
		end
		r.occupancy = pdtq_pkg::OCC_BITS'(held_count);
		r.drop_total = drop_count;
		return r;
	endfunction

	task automatic queue_msg(logic m, logic [1:0] k, logic [31:0] pl, logic drain,
			logic hold, int ph);
		msg_beat_t b;
		b.mode = m;
		b.kind = k;
		b.payload = pl;
		b.drain = drain;
		b.rx_hold = hold;
		b.phase = ph[1:0];
		pending_msgs.push_back(b);
	endtask

	task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] exp_val);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("result beat %0d: %s is %0h, expected %0h", result_count, field, got,
				exp_val);
	endtask

	// Sender: a beat that has been offered stays put until it is taken.
	always @(negedge clk) begin
		if (arst_n && !(in_valid && !beat_taken)) begin
			if (pending_msgs.size() != 0
					&& !(pending_msgs[0].drain && expected_results.size() != 0)
					&& $urandom_range(0, 99) >= send_idle_pct[pending_msgs[0].phase]) begin
				next_msg = pending_msgs.pop_front();
				driven_msg = next_msg;
				mode <= next_msg.mode;
				message_kind <= next_msg.kind;
				message_payload <= next_msg.payload;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, plus long hold-offs requested by the stimulus.
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_hold_left != 0) begin
				rx_hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct[cur_phase]);
			end
		end
	end

	always @(posedge clk) begin
		beat_taken = arst_n && in_valid && in_ready;
		if (beat_taken) begin
			expected_results.push_back(queue_step(driven_msg));
			cur_phase = 32'(driven_msg.phase);
			if (driven_msg.rx_hold)
				rx_hold_left = RX_HOLD_CYCLES;
		end
		if (arst_n && out_valid && out_ready) begin
			result_count++;
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected beat, occupancy", 32'(occupancy), '0);
			end else begin
				want = expected_results.pop_front();
				if (accepted !== want.accepted)
					report_mismatch("accepted", 32'(accepted), 32'(want.accepted));
				if (evicted !== want.evicted)
					report_mismatch("evicted", 32'(evicted), 32'(want.evicted));
				if (pop_valid !== want.pop_valid)
					report_mismatch("pop_valid", 32'(pop_valid), 32'(want.pop_valid));
				if (pop_kind !== want.pop_kind)
					report_mismatch("pop_kind", 32'(pop_kind), 32'(want.pop_kind));
				if (pop_payload !== want.pop_payload)
					report_mismatch("pop_payload", pop_payload, want.pop_payload);
				if (occupancy !== want.occupancy)
					report_mismatch("occupancy", 32'(occupancy), 32'(want.occupancy));
				if (drop_total !== want.drop_total)
					report_mismatch("drop_total", drop_total, want.drop_total);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("priority_drop_tx_queue_core regression: fail");
			$finish;
		end
	end

	initial begin
		int ph;
		int n;
		int i;
		int style;
		int roll;
		int push_pct [4];
		logic [1:0] kd;
		logic [31:0] pl;
		push_pct = '{80, 80, 30, 55};

		// Empty pop, refused kind, then a short push/pop round trip.
		queue_msg(pdtq_pkg::MODE_POP, pdtq_pkg::KIND_REFUSED, '1, 1'b0, 1'b0, 0);
		queue_msg(pdtq_pkg::MODE_PUSH, pdtq_pkg::KIND_REFUSED, '1, 1'b0, 1'b0, 0);
		queue_msg(pdtq_pkg::MODE_PUSH, pdtq_pkg::KIND_START, '0, 1'b0, 1'b0, 0);
		queue_msg(pdtq_pkg::MODE_PUSH, pdtq_pkg::KIND_END, '1, 1'b0, 1'b0, 0);
		queue_msg(pdtq_pkg::MODE_POP, pdtq_pkg::KIND_UPDATE, 32'h1234_5678, 1'b0, 1'b0, 0);
		queue_msg(pdtq_pkg::MODE_POP, pdtq_pkg::KIND_START, '0, 1'b0, 1'b0, 0);
		// Fill to the brim across the ring wrap with a single update in the middle.
		for (i = 0; i < DEPTH; i++)
			queue_msg(pdtq_pkg::MODE_PUSH, (i == 5) ? pdtq_pkg::KIND_UPDATE
				: ((i % 2) ? pdtq_pkg::KIND_END : pdtq_pkg::KIND_START),
				32'h5A00_0000 | 32'(i), 1'b0, 1'b0, 0);
		// First overflow drops the update, the second finds none and drops the head.
		queue_msg(pdtq_pkg::MODE_PUSH, pdtq_pkg::KIND_END, 32'hFFFF_0000, 1'b0, 1'b0, 0);
		queue_msg(pdtq_pkg::MODE_PUSH, pdtq_pkg::KIND_START, 32'h0000_FFFF, 1'b0, 1'b0, 0);
		queue_msg(pdtq_pkg::MODE_POP, pdtq_pkg::KIND_REFUSED, '1, 1'b0, 1'b0, 0);

		for (ph = 0; ph < 3; ph++) begin
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				// Segments lean toward filling (with or without updates) or draining.
				if (n % 32 == 0)
					style = $urandom_range(0, 3);
				roll = $urandom_range(0, 99);
				pl = ($urandom_range(0, 15) == 0) ? ($urandom_range(0, 1) ? '1 : '0) : $urandom;
				if (roll < push_pct[style]) begin
					roll = $urandom_range(0, 99);
					if (roll < 8)
						kd = pdtq_pkg::KIND_REFUSED;
					else if (style != 1 && roll < 45)
						kd = pdtq_pkg::KIND_UPDATE;
					else
						kd = (roll % 2) ? pdtq_pkg::KIND_END : pdtq_pkg::KIND_START;
					queue_msg(pdtq_pkg::MODE_PUSH, kd, pl, (ph > 0 && n == 0) || n % 97 == 50,
						n == 100 && ph < 2, ph);
				end else begin
					kd = 2'($urandom_range(0, 3));
					queue_msg(pdtq_pkg::MODE_POP, kd, pl, (ph > 0 && n == 0) || n % 97 == 50,
						n == 100 && ph < 2, ph);
				end
			end
		end

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (pending_msgs.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("priority_drop_tx_queue_core regression: pass");
		else
			$display("priority_drop_tx_queue_core regression: fail");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/pdtq_pkg.sv
rtl/core/pdtq_store.sv
rtl/core/priority_drop_tx_queue_core.sv
test/testbench.sv
